// ----- src/pwmg_pkg.sv -----
// Shared types and constants for the multichannel PWM generator.
// No dependencies; used by pwmg_channel and multichannel_pwm_generator.
package pwmg_pkg;

  // Number of channels actually built (1 to 4); the channel field stays 2 bits.
  localparam int unsigned CHANNELS = 4;
  localparam int unsigned CH_SLOTS = 4;

  localparam int unsigned OD_W = 8;
  localparam int unsigned HC_W = 8;
  localparam int unsigned SD_W = 4;
  localparam int unsigned PS_W = 16;
  localparam int unsigned PC_W = 8;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    SEL_OUT_DIV  = 2'd0,
    SEL_HIGH_CNT = 2'd1,
    SEL_SRC_DIV  = 2'd2,
    SEL_NONE     = 2'd3
  } reg_sel_t;

  // Command from the top level to one channel.
  typedef struct packed {
    logic            tick;
    logic            write;
    logic            hit;
    reg_sel_t        sel;
    logic [OD_W-1:0] value;
  } chan_cmd_t;

  // Channel state as it stands after the current word.
  typedef struct packed {
    logic [OD_W-1:0] out_divider;
    logic [HC_W-1:0] high_count;
    logic [SD_W-1:0] source_divider;
    logic            level;
  } chan_status_t;

endpackage

// ----- src/multichannel_pwm_generator.sv -----
// Multichannel PWM generator: input register, channel bank, result register.
// Each accepted word passes the input register, then the result register; an
//   output stall keeps the word waiting in the input register.
// Throughput: one word per cycle unless the output stalls; each word is applied
//   to channel state on leaving the input register, so ticks advance at full rate.
// Reset (rst, synchronous): all fields and counters clear to zero, both
//   pipeline stages empty; channels start disabled and drive low.
// Depends on pwmg_pkg and pwmg_channel.
module multichannel_pwm_generator (
  input  logic        clk,
  input  logic        rst,
  // input word
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [1:0] channel, [9:2] field_value, [15:10] zero
  input  logic [3:0]  s_tuser,   // [1:0] action, [3:2] reg_select
  // result word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [7:0] read_value, [8] channel_enabled,
                                 // [12:9] pwm_levels, [15:13] zero
);

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic                      s1_valid;
  pwmg_pkg::action_t         s1_action;
  pwmg_pkg::reg_sel_t        s1_sel;
  logic [1:0]                s1_channel;
  logic [pwmg_pkg::OD_W-1:0] s1_value;

  logic advance;   // result register free to take a word
  logic s1_fire;   // word in the input register is applied this cycle

  assign advance  = !m_tvalid || m_tready;
  assign s1_fire  = s1_valid && advance;
  assign s_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_action  <= pwmg_pkg::action_t'(s_tuser[1:0]);
      s1_sel     <= pwmg_pkg::reg_sel_t'(s_tuser[3:2]);
      s1_channel <= s_tdata[1:0];
      s1_value   <= s_tdata[9:2];
    end
  end

  // ---------------------------------------------------------------------
  // Channel bank; slots beyond CHANNELS read as a disabled, all-zero channel
  // ---------------------------------------------------------------------
  pwmg_pkg::chan_status_t status [pwmg_pkg::CH_SLOTS];
  logic [pwmg_pkg::CH_SLOTS-1:0] levels;

  for (genvar g = 0; g < pwmg_pkg::CH_SLOTS; g++) begin : g_chan
    if (g < pwmg_pkg::CHANNELS) begin : g_live
      pwmg_pkg::chan_cmd_t cmd;
      assign cmd.tick  = s1_fire && (s1_action == pwmg_pkg::ACT_TICK);
      assign cmd.write = s1_fire && (s1_action == pwmg_pkg::ACT_WRITE);
      assign cmd.hit   = (s1_channel == 2'(g));
      assign cmd.sel   = s1_sel;
      assign cmd.value = s1_value;

      pwmg_channel u_chan (
        .clk    (clk),
        .rst    (rst),
        .cmd    (cmd),
        .status (status[g])
      );
    end else begin : g_absent
      assign status[g] = '0;
    end
    assign levels[g] = status[g].level;
  end

  // ---------------------------------------------------------------------
  // Result formation: fields and levels as they stand after the word
  // ---------------------------------------------------------------------
  pwmg_pkg::chan_status_t sel_status;
  logic [7:0]             read_value;
  logic                   channel_enabled;

  assign sel_status      = status[s1_channel];
  assign channel_enabled = (sel_status.out_divider != '0);

  always_comb begin
    read_value = '0;
    if (s1_action == pwmg_pkg::ACT_READ) begin
      case (s1_sel)
        pwmg_pkg::SEL_OUT_DIV:  read_value = sel_status.out_divider;
        pwmg_pkg::SEL_HIGH_CNT: read_value = sel_status.high_count;
        pwmg_pkg::SEL_SRC_DIV:  read_value = 8'(sel_status.source_divider);
        default:                read_value = '0;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      m_tdata <= {3'b000, levels, channel_enabled, read_value};
    end
  end

`ifndef SYNTHESIS
  // an empty result stage never holds back the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  // a word waiting in the input register is kept while the output stalls
  a_s1_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_channel) && $stable(s1_value)))
    else $error("input register word lost under stall");

  // both stages come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!m_tvalid && !s1_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule

// ----- src/pwmg_channel.sv -----
// One PWM channel: field registers, prescaler and period counter.
// Depends on pwmg_pkg.
module pwmg_channel (
  input  logic                  clk,
  input  logic                  rst,
  input  pwmg_pkg::chan_cmd_t    cmd,
  output pwmg_pkg::chan_status_t status
);

  logic [pwmg_pkg::OD_W-1:0] out_divider, out_divider_next;
  logic [pwmg_pkg::HC_W-1:0] high_count, high_count_next;
  logic [pwmg_pkg::SD_W-1:0] source_divider, source_divider_next;
  logic [pwmg_pkg::PS_W-1:0] prescale_count, prescale_count_next;
  logic [pwmg_pkg::PC_W-1:0] period_count, period_count_next;

  logic [4:0]                shamt;
  logic [pwmg_pkg::PS_W-1:0] last;

  // prescaler wraps at 2^(sd+1)-1; a shift of 16 leaves all ones
  assign shamt = {1'b0, source_divider} + 5'd1;
  assign last  = ~({pwmg_pkg::PS_W{1'b1}} << shamt);

  always_comb begin
    out_divider_next    = out_divider;
    high_count_next     = high_count;
    source_divider_next = source_divider;
    prescale_count_next = prescale_count;
    period_count_next   = period_count;

    if (cmd.write && cmd.hit) begin
      case (cmd.sel)
        pwmg_pkg::SEL_OUT_DIV:  out_divider_next    = cmd.value;
        pwmg_pkg::SEL_HIGH_CNT: high_count_next     = cmd.value;
        pwmg_pkg::SEL_SRC_DIV:  source_divider_next = cmd.value[pwmg_pkg::SD_W-1:0];
        default: ;
      endcase
    end

    // disabled channel keeps no counter phase
    if (cmd.write && (out_divider_next == '0)) begin
      prescale_count_next = '0;
      period_count_next   = '0;
    end

    if (cmd.tick && (out_divider != '0)) begin
      if (prescale_count >= last) begin
        prescale_count_next = '0;
        if (period_count >= out_divider) begin
          period_count_next = '0;
        end else begin
          period_count_next = period_count + 1'b1;
        end
      end else begin
        prescale_count_next = prescale_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_divider    <= '0;
      high_count     <= '0;
      source_divider <= '0;
      prescale_count <= '0;
      period_count   <= '0;
    end else begin
      out_divider    <= out_divider_next;
      high_count     <= high_count_next;
      source_divider <= source_divider_next;
      prescale_count <= prescale_count_next;
      period_count   <= period_count_next;
    end
  end

  assign status.out_divider    = out_divider_next;
  assign status.high_count     = high_count_next;
  assign status.source_divider = source_divider_next;
  assign status.level          = (out_divider_next != '0) &&
                                 (period_count_next <= high_count_next);

endmodule
